/* hdl/hpdt_pkg.sv */
`default_nettype none
package hpdt_pkg;

   localparam int TABLE_BYTES    = 4096;
   localparam int MAX_ENTRIES    = 128;
   localparam int STATIC_ENTRIES = 61;
   localparam int ENTRY_OVERHEAD = 32;

   localparam int SLOT_W  = $clog2(MAX_ENTRIES);
   localparam int COUNT_W = SLOT_W + 1;
   localparam int OFF_W   = $clog2(TABLE_BYTES);
   localparam int BYTES_W = OFF_W + 1;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_RESIZE = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_IDX  = 2'd1;
   localparam logic [1:0] ST_DECLINED = 2'd2;
   localparam logic [1:0] ST_BAD_SIZE = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_EVICT_CHECK,
      S_EVICT_WAIT,
      S_LOOK_WAIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       rd_lookup;
      logic       rd_oldest;
      logic       lookup_load;
      logic       set_static;
      logic       set_bad_idx;
      logic       set_bad_size;
      logic       add_decline;
      logic       evict_apply;
      logic       add_commit;
      logic       resize_commit;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0]         op;
      logic               idx_zero;
      logic               idx_static;
      logic               idx_in_range;
      logic               add_too_large;
      logic               add_need_evict;
      logic               lim_bad;
      logic               resize_need_evict;
      logic               rsp_busy;
      logic [COUNT_W-1:0] count;
   } stat_type;

endpackage
`default_nettype wire

/* hdl/hpdt_ctrl.sv */
`default_nettype none
module hpdt_ctrl
   import hpdt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_fire,
   input  wire stat_type stat,
   output logic      idle,
   output cmd_type   cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (stat.op)
               OP_LOOKUP: begin
                  if (!stat.idx_zero && !stat.idx_static && stat.idx_in_range)
                     state_in = S_LOOK_WAIT;
                  else
                     state_in = S_FINISH;
               end
               OP_ADD: begin
                  state_in = stat.add_too_large ? S_FINISH : S_EVICT_CHECK;
               end
               OP_RESIZE: begin
                  state_in = stat.lim_bad ? S_FINISH : S_EVICT_CHECK;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_EVICT_CHECK: begin
            if ((stat.op == OP_ADD && stat.add_need_evict) ||
                (stat.op == OP_RESIZE && stat.resize_need_evict))
               state_in = S_EVICT_WAIT;
            else
               state_in = S_FINISH;
         end
         S_EVICT_WAIT: state_in = S_EVICT_CHECK;
         S_LOOK_WAIT:  state_in = S_FINISH;
         S_FINISH: begin
            if (!stat.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      idle = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: cmd.capture = req_fire;
         S_DECODE: begin
            case (stat.op)
               OP_LOOKUP: begin
                  if (stat.idx_zero)
                     cmd.set_bad_idx = 1'b1;
                  else if (stat.idx_static)
                     cmd.set_static = 1'b1;
                  else if (stat.idx_in_range)
                     cmd.rd_lookup = 1'b1;
                  else
                     cmd.set_bad_idx = 1'b1;
               end
               OP_ADD:    cmd.add_decline  = stat.add_too_large;
               OP_RESIZE: cmd.set_bad_size = stat.lim_bad;
               default: ;
            endcase
         end
         S_EVICT_CHECK: begin
            if (stat.op == OP_ADD) begin
               if (stat.add_need_evict) cmd.rd_oldest = 1'b1;
               else cmd.add_commit = 1'b1;
            end else begin
               if (stat.resize_need_evict) cmd.rd_oldest = 1'b1;
               else cmd.resize_commit = 1'b1;
            end
         end
         S_EVICT_WAIT: cmd.evict_apply = 1'b1;
         S_LOOK_WAIT:  cmd.lookup_load = 1'b1;
         S_FINISH:     cmd.emit = !stat.rsp_busy;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

/* hdl/hpdt_dpath.sv */
`default_nettype none
module hpdt_dpath
   import hpdt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire logic [1:0]  req_op,
   input  wire logic        req_skip_value,
   input  wire logic [15:0] req_index,
   input  wire logic [15:0] req_nlen,
   input  wire logic [15:0] req_vlen,
   input  wire logic [15:0] req_lim,
   input  wire logic        rsp_ready,
   output stat_type         stat,
   output logic             rsp_valid,
   output logic             rsp_static_hit,
   output logic [63:0]      rsp_data
);

   // Each record holds name offset, name length and value length.
   logic [3*OFF_W-1:0] mem [MAX_ENTRIES];
   logic [3*OFF_W-1:0] rd_data_ff;

   logic [1:0]   op_ff;
   logic         skip_value_ff;
   logic [15:0]  index_ff, nlen_ff, vlen_ff, lim_ff;

   logic [SLOT_W-1:0]  oldest_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [BYTES_W-1:0] free_ff, limit_ff;
   logic [OFF_W-1:0]   wpos_ff;

   logic [1:0]   res_status_ff;
   logic         res_static_ff;
   logic [5:0]   res_entry_ff;
   logic [OFF_W-1:0] res_noff_ff, res_nlen_ff, res_voff_ff, res_vlen_ff;
   logic [7:0]   res_evicted_ff;

   logic         rsp_valid_ff;
   logic         rsp_static_ff;
   logic [63:0]  rsp_data_ff;

   logic [17:0]        charge;
   logic signed [17:0] needed;
   logic [15:0]        dyn_pos;
   logic [15:0]        look_slot;
   logic [SLOT_W-1:0]  new_slot;
   logic [OFF_W-1:0]   rd_noff, rd_nlen, rd_vlen;
   logic [17:0]        evict_bytes;

   assign charge    = 18'(nlen_ff) + 18'(vlen_ff) + 18'(ENTRY_OVERHEAD);
   assign needed    = $signed({5'd0, limit_ff}) - $signed({2'd0, lim_ff});
   assign dyn_pos   = index_ff - 16'(STATIC_ENTRIES + 1);
   assign look_slot = 16'(oldest_ff) + 16'(count_ff) - 16'd1 - dyn_pos;
   assign new_slot  = oldest_ff + count_ff[SLOT_W-1:0];
   assign {rd_noff, rd_nlen, rd_vlen} = rd_data_ff;
   assign evict_bytes = 18'(free_ff) + 18'(ENTRY_OVERHEAD) + 18'(rd_nlen) + 18'(rd_vlen);

   always_comb begin
      stat.op                = op_ff;
      stat.idx_zero          = (index_ff == 16'd0);
      stat.idx_static        = (index_ff <= 16'(STATIC_ENTRIES));
      stat.idx_in_range      = (dyn_pos < 16'(count_ff));
      stat.add_too_large     = (charge > 18'(limit_ff)) && (charge > 18'(free_ff));
      stat.add_need_evict    = ((charge > 18'(free_ff)) && (count_ff != '0)) ||
                               (count_ff >= COUNT_W'(MAX_ENTRIES));
      stat.lim_bad           = (lim_ff > 16'(TABLE_BYTES));
      stat.resize_need_evict = (needed > $signed({5'd0, free_ff})) && (count_ff != '0);
      stat.rsp_busy          = rsp_valid_ff && !rsp_ready;
      stat.count             = count_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_lookup) rd_data_ff <= mem[look_slot[SLOT_W-1:0]];
      else if (cmd.rd_oldest) rd_data_ff <= mem[oldest_ff];
      if (cmd.add_commit) mem[new_slot] <= {wpos_ff, nlen_ff[OFF_W-1:0], vlen_ff[OFF_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff         <= req_op;
         skip_value_ff <= req_skip_value;
         index_ff      <= req_index;
         nlen_ff       <= req_nlen;
         vlen_ff       <= req_vlen;
         lim_ff        <= req_lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         count_ff  <= '0;
         free_ff   <= BYTES_W'(TABLE_BYTES);
         limit_ff  <= BYTES_W'(TABLE_BYTES);
         wpos_ff   <= '0;
      end else begin
         if (cmd.add_decline) begin
            count_ff <= '0;
            free_ff  <= limit_ff;
         end
         if (cmd.evict_apply) begin
            free_ff   <= evict_bytes[BYTES_W-1:0];
            oldest_ff <= oldest_ff + SLOT_W'(1);
            count_ff  <= count_ff - COUNT_W'(1);
         end
         if (cmd.add_commit) begin
            free_ff  <= free_ff - charge[BYTES_W-1:0];
            count_ff <= count_ff + COUNT_W'(1);
            wpos_ff  <= wpos_ff + nlen_ff[OFF_W-1:0] + vlen_ff[OFF_W-1:0];
         end
         if (cmd.resize_commit) begin
            if (needed > $signed({5'd0, free_ff}))
               free_ff <= lim_ff[BYTES_W-1:0];
            else
               free_ff <= free_ff - needed[BYTES_W-1:0];
            limit_ff <= lim_ff[BYTES_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_status_ff  <= ST_OK;
         res_static_ff  <= 1'b0;
         res_entry_ff   <= '0;
         res_noff_ff    <= '0;
         res_nlen_ff    <= '0;
         res_voff_ff    <= '0;
         res_vlen_ff    <= '0;
         res_evicted_ff <= '0;
      end
      if (cmd.set_bad_idx)  res_status_ff <= ST_BAD_IDX;
      if (cmd.set_bad_size) res_status_ff <= ST_BAD_SIZE;
      if (cmd.set_static) begin
         res_static_ff <= 1'b1;
         res_entry_ff  <= index_ff[5:0];
      end
      if (cmd.add_decline) begin
         res_status_ff  <= ST_DECLINED;
         res_evicted_ff <= 8'(count_ff);
      end
      if (cmd.evict_apply) res_evicted_ff <= res_evicted_ff + 8'd1;
      if (cmd.lookup_load) begin
         res_noff_ff <= rd_noff;
         res_nlen_ff <= rd_nlen;
         if (!skip_value_ff) begin
            res_voff_ff <= rd_noff + rd_nlen;
            res_vlen_ff <= rd_vlen;
         end
      end
      if (cmd.add_commit) begin
         res_noff_ff <= wpos_ff;
         res_nlen_ff <= nlen_ff[OFF_W-1:0];
         res_voff_ff <= wpos_ff + nlen_ff[OFF_W-1:0];
         res_vlen_ff <= vlen_ff[OFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_static_ff <= res_static_ff;
         rsp_data_ff   <= {res_evicted_ff, res_vlen_ff, res_voff_ff, res_nlen_ff,
                           res_noff_ff, res_entry_ff, res_status_ff};
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_static_hit = rsp_static_ff;
   assign rsp_data       = rsp_data_ff;

endmodule
`default_nettype wire

/* hdl/hpack_dynamic_table_index_unit.sv */
// HPACK dynamic table index and accounting unit.
// Input words arrive on req_*: tuser selects lookup, add or resize, tdata
// carries the index, the name and value lengths and the new limit. One
// result word per input word leaves on rsp_*: status, static entry, ring
// offsets and lengths of the entry, and the number of entries evicted.
// The header bytes themselves live in an external ring; this unit only
// tracks offsets, lengths and byte accounting in a 128-entry record memory.
// One word is processed at a time. A static or invalid lookup, a declined
// add, a rejected resize or an unknown operation goes from decode to the
// finish step; a dynamic lookup first makes one registered memory read, and
// an add or resize without eviction first passes the eviction check. Every
// evicted entry adds a read of the oldest record, then a credit of bytes.
// req_tready is high only while the unit is idle and rises together with
// rsp_tvalid, so the next word can be accepted while a result still waits
// on a stalled rsp_tready; that word then holds in its last step until the
// output register is free.
// Synchronous reset empties the table, sets the limit to 4096 bytes and
// drops any pending result. No clearing pass is needed.
`default_nettype none
module hpack_dynamic_table_index_unit
   import hpdt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // lookup_index, add_name_length, add_value_length, new_limit
   input  wire logic [63:0] req_tdata,
   // operation, skip_value
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status, static_entry, name_offset, name_length, value_offset,
   // value_length, evicted_count
   output logic [63:0]      rsp_tdata,
   // static_hit
   output logic [0:0]       rsp_tuser
);

   cmd_type  cmd;
   stat_type stat;
   logic     idle;
   logic     req_fire;

   assign req_tready = idle;
   assign req_fire   = req_tvalid && idle;

   hpdt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .stat     (stat),
      .idle     (idle),
      .cmd      (cmd)
   );

   hpdt_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_op         (req_tuser[1:0]),
      .req_skip_value (req_tuser[2]),
      .req_index      (req_tdata[15:0]),
      .req_nlen       (req_tdata[31:16]),
      .req_vlen       (req_tdata[47:32]),
      .req_lim        (req_tdata[63:48]),
      .rsp_ready      (rsp_tready),
      .stat           (stat),
      .rsp_valid      (rsp_tvalid),
      .rsp_static_hit (rsp_tuser[0]),
      .rsp_data       (rsp_tdata)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("unit accepted a word while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= COUNT_W'(MAX_ENTRIES))
      else $error("entry count above table capacity");

   a_static_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[1:0] == ST_OK)
      else $error("static hit with error status");

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import hpdt_pkg::*;

   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam int DRAIN_CYCLES = 2 * MAX_ENTRIES * 2 + 40;

   typedef struct {
      logic [1:0]  op;
      logic [15:0] index;
      logic        skip_value;
      logic [15:0] name_len;
      logic [15:0] value_len;
      logic [15:0] limit;
   } table_op_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        static_hit;
      logic [5:0]  static_entry;
      logic [11:0] name_off;
      logic [11:0] name_len;
      logic [11:0] value_off;
      logic [11:0] value_len;
      logic [7:0]  evicted;
   } table_rsp_type;

   typedef struct {
      table_op_type  item;
      bit            typed;
      table_rsp_type want;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   hpack_dynamic_table_index_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Shadow copy of the table bookkeeping.
   int unsigned rec_name_off [MAX_ENTRIES];
   int unsigned rec_name_len [MAX_ENTRIES];
   int unsigned rec_value_len[MAX_ENTRIES];
   int unsigned oldest;
   int unsigned live_count;
   int unsigned free_space;
   int unsigned table_limit;
   int unsigned write_pos;

   table_rsp_type    pending_rsps[$];
   directed_row_type directed[$];
   int unsigned      mismatches = 0;
   int unsigned      rx_hold = 0;
   bit               no_idle;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic void drop_oldest();
      free_space += ENTRY_OVERHEAD + rec_name_len[oldest] + rec_value_len[oldest];
      oldest = (oldest + 1) % MAX_ENTRIES;
      live_count--;
   endfunction

   function automatic table_rsp_type table_update(table_op_type t);
      table_rsp_type r;
      int unsigned charge, depth, slot, ev;
      int needed;
      r = '{default: '0};
      ev = 0;
      case (t.op)
         OP_LOOKUP: begin
            if (t.index == 0) r.status = ST_BAD_IDX;
            else if (t.index <= STATIC_ENTRIES) begin
               r.static_hit = 1'b1;
               r.static_entry = t.index[5:0];
            end else begin
               depth = t.index - STATIC_ENTRIES - 1;
               if (depth < live_count) begin
                  slot = (oldest + live_count - 1 - depth) % MAX_ENTRIES;
                  r.name_off = 12'(rec_name_off[slot]);
                  r.name_len = 12'(rec_name_len[slot]);
                  if (!t.skip_value) begin
                     r.value_off = 12'((rec_name_off[slot] + rec_name_len[slot]) % TABLE_BYTES);
                     r.value_len = 12'(rec_value_len[slot]);
                  end
               end else r.status = ST_BAD_IDX;
            end
         end
         OP_ADD: begin
            charge = t.name_len + t.value_len + ENTRY_OVERHEAD;
            if (charge > table_limit && charge > free_space) begin
               ev = live_count;
               live_count = 0;
               free_space = table_limit;
               r.status = ST_DECLINED;
            end else begin
               while (charge > free_space && live_count > 0) begin
                  drop_oldest();
                  ev++;
               end
               if (live_count >= MAX_ENTRIES) begin
                  drop_oldest();
                  ev++;
               end
               free_space -= charge;
               slot = (oldest + live_count) % MAX_ENTRIES;
               rec_name_off[slot] = write_pos;
               rec_name_len[slot] = t.name_len;
               rec_value_len[slot] = t.value_len;
               live_count++;
               r.name_off = 12'(write_pos);
               r.name_len = t.name_len[11:0];
               r.value_off = 12'((write_pos + t.name_len) % TABLE_BYTES);
               r.value_len = t.value_len[11:0];
               write_pos = (write_pos + t.name_len + t.value_len) % TABLE_BYTES;
            end
         end
         OP_RESIZE: begin
            if (t.limit > TABLE_BYTES) r.status = ST_BAD_SIZE;
            else begin
               needed = int'(table_limit) - int'(t.limit);
               while (needed > int'(free_space) && live_count > 0) begin
                  drop_oldest();
                  ev++;
               end
               if (needed > int'(free_space)) free_space = t.limit;
               else free_space = int'(free_space) - needed;
               table_limit = t.limit;
            end
         end
         default: ;
      endcase
      r.evicted = ev[7:0];
      return r;
   endfunction

   task automatic send_word(table_op_type t, bit typed, table_rsp_type want);
      table_rsp_type predicted;
      while (!no_idle && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t.limit, t.value_len, t.name_len, t.index};
      req_tuser  <= {t.skip_value, t.op};
      do @(posedge clock); while (!req_tready);
      predicted = table_update(t);
      pending_rsps.push_back(typed ? want : predicted);
   endtask

   function automatic table_op_type random_word();
      table_op_type t;
      int unsigned pick;
      t.op = 2'($urandom_range(3));
      t.index = 16'($urandom);
      t.skip_value = 1'($urandom_range(1));
      t.name_len = 16'($urandom);
      t.value_len = 16'($urandom);
      t.limit = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 45) begin
         t.op = OP_ADD;
         pick = $urandom_range(99);
         if (pick < 80) begin
            t.name_len = 16'($urandom_range(60));
            t.value_len = 16'($urandom_range(60));
         end else if (pick < 95) begin
            t.name_len = 16'($urandom_range(2100));
            t.value_len = 16'($urandom_range(2100));
         end
      end else if (pick < 80) begin
         t.op = OP_LOOKUP;
         pick = $urandom_range(99);
         if (pick < 70) t.index = 16'(STATIC_ENTRIES + 1 + $urandom_range(live_count));
         else if (pick < 85) t.index = 16'($urandom_range(STATIC_ENTRIES));
      end else if (pick < 93) begin
         t.op = OP_RESIZE;
         pick = $urandom_range(99);
         if (pick < 80) t.limit = 16'($urandom_range(TABLE_BYTES));
         else if (pick < 90) t.limit = 16'(TABLE_BYTES);
      end else if (pick < 97) t.op = OP_UNKNOWN;
      else begin
         t.op = OP_ADD;
         t.name_len = 16'd0;
         t.value_len = 16'd0;
      end
      return t;
   endfunction

   task automatic add_row(logic [1:0] op, int index, bit skip_value, int name_len,
                          int value_len, int limit, bit typed, table_rsp_type want);
      directed_row_type row;
      row.item = '{op, index[15:0], skip_value, name_len[15:0], value_len[15:0],
                   limit[15:0]};
      row.typed = typed;
      row.want = want;
      directed.push_back(row);
   endtask

   // Receiver: checks each result word and stalls at random.
   always @(posedge clock) begin
      table_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status       = rsp_tdata[1:0];
         got.static_entry = rsp_tdata[7:2];
         got.name_off     = rsp_tdata[19:8];
         got.name_len     = rsp_tdata[31:20];
         got.value_off    = rsp_tdata[43:32];
         got.value_len    = rsp_tdata[55:44];
         got.evicted      = rsp_tdata[63:56];
         got.static_hit   = rsp_tuser[0];
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_tdata);
         end else begin
            want = pending_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else rsp_tready <= no_idle || $urandom_range(99) >= 6;
   end

   initial begin
      table_rsp_type none, want;
      table_op_type t;
      int unsigned waited;
      none = '{default: '0};
      no_idle = 1'b0;
      oldest = 0;
      live_count = 0;
      free_space = TABLE_BYTES;
      table_limit = TABLE_BYTES;
      write_pos = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      want = none; want.status = ST_BAD_IDX;
      add_row(OP_LOOKUP, 0, 0, 0, 0, 0, 1, want);
      add_row(OP_LOOKUP, 62, 0, 0, 0, 0, 1, want);
      add_row(OP_LOOKUP, 65535, 1, 65535, 65535, 65535, 1, want);
      want = none; want.static_hit = 1'b1; want.static_entry = 6'd1;
      add_row(OP_LOOKUP, 1, 0, 0, 0, 0, 1, want);
      want.static_entry = 6'd61;
      add_row(OP_LOOKUP, 61, 1, 0, 0, 0, 1, want);
      want = none; want.status = ST_BAD_SIZE;
      add_row(OP_RESIZE, 0, 0, 0, 0, 4097, 1, want);
      add_row(OP_RESIZE, 65535, 1, 65535, 65535, 65535, 1, want);
      want = none; want.status = ST_DECLINED;
      add_row(OP_ADD, 0, 0, 65535, 65535, 0, 1, want);
      want = none; want.name_len = 12'd10; want.value_off = 12'd10; want.value_len = 12'd20;
      add_row(OP_ADD, 0, 0, 10, 20, 0, 1, want);
      add_row(OP_LOOKUP, 62, 1, 0, 0, 0, 0, none);
      add_row(OP_LOOKUP, 62, 0, 0, 0, 0, 0, none);
      add_row(OP_ADD, 0, 0, 4000, 0, 0, 0, none);
      add_row(OP_UNKNOWN, 65535, 1, 65535, 65535, 65535, 1, none);
      add_row(OP_RESIZE, 0, 0, 0, 0, 0, 0, none);
      add_row(OP_ADD, 0, 0, 0, 0, 0, 0, none);
      add_row(OP_RESIZE, 0, 0, 0, 0, 4096, 0, none);
      add_row(OP_ADD, 0, 0, 4064, 0, 0, 0, none);
      add_row(OP_ADD, 0, 0, 0, 0, 0, 0, none);
      add_row(OP_LOOKUP, 63, 0, 0, 0, 0, 0, none);
      add_row(OP_RESIZE, 0, 0, 0, 0, 100, 0, none);
      add_row(OP_ADD, 0, 0, 30, 38, 0, 0, none);
      add_row(OP_RESIZE, 0, 0, 0, 0, 4096, 0, none);
      foreach (directed[i]) send_word(directed[i].item, directed[i].typed, directed[i].want);

      // Fill all 128 slots with minimal entries, then push one more through.
      t = '{OP_ADD, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0};
      for (int i = 0; i < MAX_ENTRIES + 1; i++) send_word(t, 0, none);

      for (int n = 0; n < 1300; n++) begin
         if (n == 200) rx_hold = 300;
         if (n == 400) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_rsps.size() != 0) @(posedge clock);
         end
         no_idle = (n >= 600 && n < 800);
         send_word(random_word(), 0, none);
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (pending_rsps.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_rsps.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
hdl/hpdt_pkg.sv
hdl/hpdt_ctrl.sv
hdl/hpdt_dpath.sv
hdl/hpack_dynamic_table_index_unit.sv
test/tb.sv
